### sv/fcd_pkg.sv
package fcd_pkg;

   localparam int DEF_MAX_WIDTH  = 256;
   localparam int DEF_MAX_HEIGHT = 256;
   localparam int DEF_MAX_RADIUS = 63;

   localparam int DIM_W   = 9;
   localparam int CRD_W   = 10;
   localparam int RAD_W   = 6;
   localparam int CHAN_W  = 8;
   localparam int PIX_W   = 3 * CHAN_W;
   localparam int COUNT_W = 14;
   localparam int OPC_W   = 2;
   localparam int CSR_IDX_W = 1;

   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 40;

   localparam logic [OPC_W-1:0] OP_DRAW  = 2'd0;
   localparam logic [OPC_W-1:0] OP_WRITE = 2'd1;
   localparam logic [OPC_W-1:0] OP_READ  = 2'd2;
   localparam logic [OPC_W-1:0] OP_NOP   = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 1'd1;

   localparam logic [DIM_W-1:0] DIM_RESET = 9'd256;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } fcd_state_type;

   typedef struct packed {
      logic valid;
      logic last;
      logic in_img;
      logic hit;
   } pix_type;

endpackage

### sv/fcd_store.sv
module fcd_store
   import fcd_pkg::*;
#(
   parameter int DEPTH = DEF_MAX_WIDTH * DEF_MAX_HEIGHT,
   parameter int AW    = $clog2(DEF_MAX_WIDTH * DEF_MAX_HEIGHT)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [PIX_W-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [PIX_W-1:0] rd_data
);

   logic [PIX_W-1:0] mem [DEPTH];
   logic [PIX_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/fcd_scan.sv
module fcd_scan
   import fcd_pkg::*;
#(
   parameter int MAX_RADIUS = DEF_MAX_RADIUS,
   parameter int AW         = $clog2(DEF_MAX_WIDTH * DEF_MAX_HEIGHT)
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic signed [CRD_W-1:0]              center_x,
   input  logic signed [CRD_W-1:0]              center_y,
   input  logic [$clog2(MAX_RADIUS + 1)-1:0]    radius,
   input  logic [DIM_W-1:0]                     width,
   input  logic [DIM_W-1:0]                     height,
   output pix_type                              pix,
   output logic [AW-1:0]                        addr
);

   localparam int RW   = $clog2(MAX_RADIUS + 1);
   localparam int OW   = RW + 1;
   localparam int XW   = ((CRD_W > OW) ? CRD_W : OW) + 1;
   localparam int SQW  = 2 * RW;
   localparam int PRDW = 2 * DIM_W;

   logic                  busy_ff, busy_in;
   logic signed [OW-1:0]  dx_ff, dx_in, dy_ff, dy_in;
   logic signed [OW-1:0]  r_s;
   logic [RW-1:0]         r_ff;
   logic [SQW-1:0]        rr_ff;
   logic signed [XW-1:0]  cx_ff, cy_ff;
   logic [DIM_W-1:0]      w_ff, h_ff;
   logic                  last0;

   logic                  v1_ff, last1_ff;
   logic signed [XW-1:0]  x1_ff, y1_ff;
   logic [SQW-1:0]        sqx_ff, sqy_ff;
   logic signed [2*OW-1:0] px, py;

   logic                  in_img;
   logic [SQW:0]          sq_sum;
   logic [PRDW-1:0]       prod;
   pix_type               pix_ff;
   logic [AW-1:0]         addr_ff;

   assign r_s   = $signed({1'b0, r_ff});
   assign last0 = (dx_ff == r_s) && (dy_ff == r_s);

   always_comb begin
      busy_in = busy_ff;
      dx_in   = dx_ff;
      dy_in   = dy_ff;
      if (start) begin
         busy_in = 1'b1;
         dx_in   = -$signed({1'b0, radius});
         dy_in   = -$signed({1'b0, radius});
      end else if (busy_ff) begin
         if (dx_ff == r_s) begin
            dx_in = -r_s;
            dy_in = dy_ff + OW'(1);
            if (dy_ff == r_s) begin
               busy_in = 1'b0;
            end
         end else begin
            dx_in = dx_ff + OW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      dx_ff <= dx_in;
      dy_ff <= dy_in;
      if (start) begin
         r_ff  <= radius;
         rr_ff <= SQW'(radius) * SQW'(radius);
         cx_ff <= XW'(center_x);
         cy_ff <= XW'(center_y);
         w_ff  <= width;
         h_ff  <= height;
      end
   end

   assign px = dx_ff * dx_ff;
   assign py = dy_ff * dy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= busy_ff;
      end
   end

   always_ff @(posedge clock) begin
      last1_ff <= last0;
      x1_ff    <= cx_ff + XW'(dx_ff);
      y1_ff    <= cy_ff + XW'(dy_ff);
      sqx_ff   <= px[SQW-1:0];
      sqy_ff   <= py[SQW-1:0];
   end

   assign in_img = !x1_ff[XW-1] && !y1_ff[XW-1]
                   && ($unsigned(x1_ff) < XW'(w_ff))
                   && ($unsigned(y1_ff) < XW'(h_ff));
   assign sq_sum = {1'b0, sqx_ff} + {1'b0, sqy_ff};
   assign prod   = PRDW'(y1_ff[DIM_W-1:0] * w_ff) + PRDW'(x1_ff[DIM_W-1:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         pix_ff.valid <= 1'b0;
      end else begin
         pix_ff.valid <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      pix_ff.last   <= last1_ff;
      pix_ff.in_img <= in_img;
      pix_ff.hit    <= in_img && (sq_sum <= {1'b0, rr_ff});
      addr_ff       <= AW'(prod);
   end

   assign pix  = pix_ff;
   assign addr = addr_ff;

endmodule

### sv/filled_circle_framebuffer_draw.sv
// Channel | Direction | Handshake             | Payload
// req     | in        | req_tvalid/req_tready | tuser opcode; tdata center, radius, color
// rsp     | out       | rsp_tvalid/rsp_tready | tdata read color, pixels_written, out_of_bounds
// csr     | in        | csr_valid/csr_ready   | csr_index, csr_data
//
// In a draw, the scanner visits one pixel of the bounding square of the saturated
// radius per cycle and the pixel store takes one write per cycle. Write and read
// items scan only the center pixel; a no-op item does not scan.
// Reset clears the control state and sets both image bounds to 256; the pixel store
// is not cleared. A new item is taken while the previous result waits on rsp_tready.
module filled_circle_framebuffer_draw
   import fcd_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
   parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // opcode
   input  logic [OPC_W-1:0]      req_tuser,
   // center_x, center_y, radius, red, green, blue, zero fill
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // read_red, read_green, read_blue, pixels_written, out_of_bounds, zero fill
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [DIM_W-1:0]      csr_data
);

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = $clog2(DEPTH);
   localparam int RW    = $clog2(MAX_RADIUS + 1);

   fcd_state_type        state_ff, state_in;
   logic [DIM_W-1:0]     width_ff, height_ff, w_eff, h_eff;
   logic [OPC_W-1:0]     op_ff, op_in;
   logic [PIX_W-1:0]     color_ff, color_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic                 oob_ff, oob_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [RAD_W-1:0]     req_radius;
   logic [RW-1:0]        r_sat, r_scan;
   logic                 scan_start;
   pix_type              pix;
   logic [AW-1:0]        pix_addr;
   logic                 mem_we, mem_re;
   logic [PIX_W-1:0]     rd_data, rd_color;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_RESET;
         height_ff <= DIM_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  width_ff  <= csr_data;
            CSR_IMAGE_HEIGHT: height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign w_eff = (width_ff > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : width_ff;
   assign h_eff = (height_ff > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : height_ff;

   assign req_radius = req_tdata[25:20];
   assign r_sat  = (req_radius > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(req_radius);
   assign r_scan = (req_tuser == OP_DRAW) ? r_sat : '0;

   fcd_scan #(
      .MAX_RADIUS(MAX_RADIUS),
      .AW        (AW)
   ) u_scan (
      .clock   (clock),
      .reset   (reset),
      .start   (scan_start),
      .center_x(req_tdata[9:0]),
      .center_y(req_tdata[19:10]),
      .radius  (r_scan),
      .width   (w_eff),
      .height  (h_eff),
      .pix     (pix),
      .addr    (pix_addr)
   );

   fcd_store #(
      .DEPTH(DEPTH),
      .AW   (AW)
   ) u_store (
      .clock  (clock),
      .wr_en  (mem_we),
      .wr_addr(pix_addr),
      .wr_data(color_ff),
      .rd_en  (mem_re),
      .rd_addr(pix_addr),
      .rd_data(rd_data)
   );

   assign rd_color = ((op_ff == OP_READ) && !oob_ff) ? rd_data : '0;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      color_in     = color_ff;
      count_in     = count_ff;
      oob_in       = oob_ff;
      scan_start   = 1'b0;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      req_tready   = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               op_in    = req_tuser;
               color_in = {req_tdata[33:26], req_tdata[41:34], req_tdata[49:42]};
               count_in = '0;
               oob_in   = 1'b0;
               if (req_tuser == OP_NOP) begin
                  state_in = ST_DONE;
               end else begin
                  scan_start = 1'b1;
                  state_in   = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (pix.valid) begin
               if (op_ff == OP_READ) begin
                  mem_re = pix.in_img;
               end else if (pix.hit) begin
                  mem_we   = 1'b1;
                  count_in = count_ff + COUNT_W'(1);
               end
               if (op_ff != OP_DRAW) begin
                  oob_in = !pix.in_img;
               end
               if (pix.last) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {1'b0, oob_ff, count_ff, rd_color[7:0], rd_color[15:8],
                               rd_color[23:16]};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      color_ff    <= color_in;
      count_ff    <= count_in;
      oob_ff      <= oob_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

### sv/fcd_checker.sv
module fcd_checker
   import fcd_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   // A waiting result beat stays until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp_tvalid dropped before the beat was taken");

   // Only one item is worked on at a time.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second request taken while an item is in progress");

   // An out-of-bounds access never changes a pixel.
   a_oob_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[38] |-> rsp_tdata[37:24] == '0)
      else $error("out-of-bounds result reports written pixels");

   // A result that wrote pixels carries no read color.
   a_write_color: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[37:24] != '0) |-> rsp_tdata[23:0] == '0)
      else $error("writing result carries read color");

endmodule

bind filled_circle_framebuffer_draw fcd_checker u_fcd_checker (.*);
